@@ design/irpd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the pulse-distance IR frame decoder.
// Depends on nothing; every design file imports it.
package irpd_pkg;

   localparam int unsigned OldBits   = 6;
   localparam int unsigned NewBits   = 15;
   localparam int unsigned CountW    = 6;
   localparam int unsigned IndexW    = 5;
   localparam int unsigned LenW      = 16;
   localparam int unsigned TimeW     = 32;
   localparam int unsigned WindowW   = 20;

   localparam logic [LenW-1:0] OLD_MARK_MAX  = LenW'(1000);
   localparam logic [LenW-1:0] OLD_SPACE_MIN = LenW'(750);
   localparam logic [LenW-1:0] OLD_SPACE_MAX = LenW'(7000);
   localparam logic [LenW-1:0] OLD_ONE_ABOVE = LenW'(2500);
   localparam logic [LenW-1:0] NEW_MARK_MAX  = LenW'(640);
   localparam logic [LenW-1:0] NEW_SPACE_MIN = LenW'(340);
   localparam logic [LenW-1:0] NEW_SPACE_MAX = LenW'(3360);
   localparam logic [LenW-1:0] NEW_ONE_ABOVE = LenW'(1180);

   localparam logic [CountW-1:0]  OLD_EVENTS    = CountW'(13);
   localparam logic [CountW-1:0]  NEW_EVENTS    = CountW'(31);
   localparam logic [CountW-1:0]  COUNT_MAX     = CountW'(63);
   localparam logic [IndexW-1:0]  INDEX_MAX     = IndexW'(31);
   localparam logic [WindowW-1:0] WINDOW_RESET  = WindowW'(80000);

   localparam logic [NewBits-1:0] CHECK_FLIP = 15'h7FE0;

   typedef enum logic {
      FRAME_OLD = 1'b0,
      FRAME_NEW = 1'b1
   } frame_type_type;

   typedef struct packed {
      logic [CountW-1:0]  event_count;
      logic [IndexW-1:0]  space_index;
      logic [OldBits-1:0] old_bits;
      logic [NewBits-1:0] new_bits;
      logic               old_reject;
      logic               new_reject;
   } burst_type;

endpackage

@@ design/irpd_burst_acc.sv @@
`timescale 1ns / 1ps
// Per-burst accumulator: event count, space index, bit words and reject flags.
// Depends on irpd_pkg.
module irpd_burst_acc import irpd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic            is_space,
   input  logic [LenW-1:0] length_us,
   input  logic            end_of_burst,
   output burst_type       burst_next
);

   burst_type burst_ff;
   burst_type burst_in;
   logic      old_one;
   logic      new_one;

   always_comb begin
      old_one = length_us > OLD_ONE_ABOVE;
      new_one = length_us > NEW_ONE_ABOVE;
      burst_next = burst_ff;
      if (burst_ff.event_count != COUNT_MAX) begin
         burst_next.event_count = burst_ff.event_count + CountW'(1);
      end
      if (!is_space) begin
         if (length_us > OLD_MARK_MAX) burst_next.old_reject = 1'b1;
         if (length_us > NEW_MARK_MAX) burst_next.new_reject = 1'b1;
      end else begin
         if (length_us < OLD_SPACE_MIN || length_us > OLD_SPACE_MAX) begin
            burst_next.old_reject = 1'b1;
         end
         if (length_us < NEW_SPACE_MIN || length_us > NEW_SPACE_MAX) begin
            burst_next.new_reject = 1'b1;
         end
         for (int i = 0; i < OldBits; i++) begin
            if (burst_ff.space_index == IndexW'(i) && old_one) burst_next.old_bits[i] = 1'b1;
         end
         for (int i = 0; i < NewBits; i++) begin
            if (burst_ff.space_index == IndexW'(i) && new_one) burst_next.new_bits[i] = 1'b1;
         end
         if (burst_ff.space_index != INDEX_MAX) begin
            burst_next.space_index = burst_ff.space_index + IndexW'(1);
         end
      end
   end

   always_comb begin
      burst_in = burst_ff;
      if (fire) begin
         burst_in = end_of_burst ? '0 : burst_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff <= '0;
      end else begin
         burst_ff <= burst_in;
      end
   end

endmodule

@@ design/irpd_frame_out.sv @@
`timescale 1ns / 1ps
// Frame decode at end of burst, repeat tracking and the result register.
// Depends on irpd_pkg.
module irpd_frame_out import irpd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic               end_of_burst,
   input  logic [TimeW-1:0]   time_us,
   input  burst_type          burst_next,
   input  logic [WindowW-1:0] window_us,
   output logic               emit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_frame_type,
   output logic [4:0]         rsp_address,
   output logic [7:0]         rsp_command,
   output logic               rsp_repeat_res
);

   logic               known_len;
   logic               is_new;
   logic               rejected;
   logic [TimeW-1:0]   elapsed;
   logic [NewBits-1:0] value;
   logic [4:0]         addr;
   logic [7:0]         cmd;
   logic               rep;
   logic               load;

   logic [TimeW-1:0]   prev_time_ff,  prev_time_in;
   logic [NewBits-1:0] prev_value_ff, prev_value_in;
   logic               prev_valid_ff, prev_valid_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   frame_type_type     type_ff,       type_in;
   logic [4:0]         addr_ff,       addr_in;
   logic [7:0]         cmd_ff,        cmd_in;
   logic               rep_ff,        rep_in;

   always_comb begin
      is_new    = burst_next.event_count == NEW_EVENTS;
      known_len = is_new || burst_next.event_count == OLD_EVENTS;
      rejected  = is_new ? burst_next.new_reject : burst_next.old_reject;
      emit      = end_of_burst && known_len && !rejected;
      load      = fire && emit;
      elapsed   = time_us - prev_time_ff;
      if (is_new) begin
         value = burst_next.new_bits;
         addr  = burst_next.new_bits[4:0];
         cmd   = burst_next.new_bits[12:5];
         if (burst_next.new_bits[14]) begin
            value = burst_next.new_bits ^ CHECK_FLIP;
            cmd   = ~burst_next.new_bits[12:5];
         end
      end else begin
         value = {{(NewBits-OldBits){1'b0}}, burst_next.old_bits};
         addr  = '0;
         cmd   = {2'b00, burst_next.old_bits};
      end
      // window is below the elapsed cap, so the cap never changes the compare
      rep = prev_valid_ff && value == prev_value_ff
            && elapsed[TimeW-1:WindowW] == '0 && elapsed[WindowW-1:0] < window_us;

      prev_time_in  = prev_time_ff;
      prev_value_in = prev_value_ff;
      prev_valid_in = prev_valid_ff;
      if (fire && end_of_burst && known_len) prev_time_in = time_us;
      if (load) begin
         prev_value_in = value;
         prev_valid_in = 1'b1;
      end

      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      type_in = type_ff;
      addr_in = addr_ff;
      cmd_in  = cmd_ff;
      rep_in  = rep_ff;
      if (load) begin
         type_in = is_new ? FRAME_NEW : FRAME_OLD;
         addr_in = addr;
         cmd_in  = cmd;
         rep_in  = rep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff  <= '0;
         prev_value_ff <= '0;
         prev_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prev_time_ff  <= prev_time_in;
         prev_value_ff <= prev_value_in;
         prev_valid_ff <= prev_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
      addr_ff <= addr_in;
      cmd_ff  <= cmd_in;
      rep_ff  <= rep_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_type = type_ff;
   assign rsp_address    = addr_ff;
   assign rsp_command    = cmd_ff;
   assign rsp_repeat_res = rep_ff;

endmodule

@@ design/ir_pulse_distance_frame_decoder.sv @@
`timescale 1ns / 1ps
// Pulse-distance IR frame decoder. One beat per cycle: each event beat is
// registered, then classified against the 6-bit and 15-bit formats in the
// next cycle. The end-of-burst beat of a 13- or 31-event burst that passes the
// range checks loads the result register when it fires; rsp_valid is driven by
// that register, which follows the input register. The result register frees
// the input side, so events keep flowing while a result waits; only an
// end-of-burst beat that yields a result waits on a stalled result.
// Depends on irpd_pkg, irpd_burst_acc and irpd_frame_out.
module ir_pulse_distance_frame_decoder import irpd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [WindowW-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_is_space,
   input  logic [LenW-1:0]    req_length_us,
   input  logic               req_end_of_burst,
   input  logic [TimeW-1:0]   req_time_us,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_frame_type,
   output logic [4:0]         rsp_address,
   output logic [7:0]         rsp_command,
   output logic               rsp_repeat_res
);

   logic               in_valid_ff, in_valid_in;
   logic               is_space_ff;
   logic [LenW-1:0]    length_ff;
   logic               last_ff;
   logic [TimeW-1:0]   time_ff;
   logic [WindowW-1:0] window_ff, window_in;
   logic               accept;
   logic               advance;
   logic               fire;
   logic               emit;
   burst_type          burst_next;

   always_comb begin
      advance     = !emit || !rsp_valid || !rsp_stall;
      fire        = in_valid_ff && advance;
      req_stall   = in_valid_ff && !advance;
      accept      = req_valid && !req_stall;
      in_valid_in = accept || (in_valid_ff && !advance);
      window_in   = csr_wr_en ? csr_wr_data : window_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         window_ff   <= WINDOW_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         window_ff   <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         is_space_ff <= req_is_space;
         length_ff   <= req_length_us;
         last_ff     <= req_end_of_burst;
         time_ff     <= req_time_us;
      end
   end

   irpd_burst_acc u_burst_acc (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .is_space     (is_space_ff),
      .length_us    (length_ff),
      .end_of_burst (last_ff),
      .burst_next   (burst_next)
   );

   irpd_frame_out u_frame_out (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .end_of_burst   (last_ff),
      .time_us        (time_ff),
      .burst_next     (burst_next),
      .window_us      (window_ff),
      .emit           (emit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_type (rsp_frame_type),
      .rsp_address    (rsp_address),
      .rsp_command    (rsp_command),
      .rsp_repeat_res (rsp_repeat_res)
   );

endmodule

@@ design/irpd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the IR frame decoder, bound to the top level.
// Depends on irpd_pkg and ir_pulse_distance_frame_decoder.
module irpd_checker import irpd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_frame_type,
   input logic [4:0]         rsp_address,
   input logic [7:0]         rsp_command,
   input logic               rsp_repeat_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_type)
         && $stable(rsp_address) && $stable(rsp_command) && $stable(rsp_repeat_res))
      else $error("stalled result beat changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_old_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_type == FRAME_OLD |-> rsp_address == 5'd0)
      else $error("old-format frame with nonzero address");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result beat without an input beat two cycles earlier");

endmodule

bind ir_pulse_distance_frame_decoder irpd_checker u_irpd_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ir_pulse_distance_frame_decoder: directed bursts, then random
// well-formed, corrupted and noise bursts, with a frame predictor and random stalls on both sides.
// Depends on irpd_pkg and the decoder RTL.
module tb_top;
   import irpd_pkg::*;

   localparam logic [TimeW-1:0] ELAPSED_CLAMP = 32'd5000000;
   localparam int unsigned      IDLE_LIMIT    = 500;
   localparam int unsigned      RANDOM_PULSES = 40;
   localparam int unsigned      RANDOM_FRAMES = 2;

   typedef struct packed {
      logic            is_space;
      logic [LenW-1:0] len;
   } ir_pulse_type;

   typedef struct packed {
      frame_type_type ftype;
      logic [4:0]     addr;
      logic [7:0]     cmd;
      logic           rep;
   } frame_result_type;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               csr_wr_en        = 1'b0;
   logic [WindowW-1:0] csr_wr_data      = '0;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic               req_is_space     = 1'b0;
   logic [LenW-1:0]    req_length_us    = '0;
   logic               req_end_of_burst = 1'b0;
   logic [TimeW-1:0]   req_time_us      = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic               rsp_frame_type;
   logic [4:0]         rsp_address;
   logic [7:0]         rsp_command;
   logic               rsp_repeat_res;

   ir_pulse_distance_frame_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_is_space     (req_is_space),
      .req_length_us    (req_length_us),
      .req_end_of_burst (req_end_of_burst),
      .req_time_us      (req_time_us),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_address      (rsp_address),
      .rsp_command      (rsp_command),
      .rsp_repeat_res   (rsp_repeat_res)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [CountW-1:0]  ev_count = '0;
   logic [IndexW-1:0]  sp_idx = '0;
   logic [OldBits-1:0] old_acc = '0;
   logic [NewBits-1:0] new_acc = '0;
   logic               old_bad = 1'b0;
   logic               new_bad = 1'b0;
   logic [TimeW-1:0]   last_stamp = '0;
   logic [NewBits-1:0] last_code = '0;
   logic               have_last = 1'b0;
   logic [WindowW-1:0] repeat_window = WINDOW_RESET;

   frame_result_type frame_q[$];
   ir_pulse_type     burst_q[$];
   logic [TimeW-1:0] stamp_now = '0;
   int               errors = 0;
   int               pulses_sent = 0;
   int               frames_predicted = 0;
   int               hold_left = 0;
   int               idle_cycles = 0;
   bit               steady = 1'b0;
   frame_result_type front_res;

   function automatic void decode_pulse(input logic sp, input logic [LenW-1:0] len,
                                        input logic eob, input logic [TimeW-1:0] stamp);
      logic             is_new;
      logic [TimeW-1:0] elapsed;
      logic [NewBits-1:0] code;
      frame_result_type res;
      if (ev_count != COUNT_MAX) ev_count = ev_count + 1'b1;
      if (!sp) begin
         if (len > OLD_MARK_MAX) old_bad = 1'b1;
         if (len > NEW_MARK_MAX) new_bad = 1'b1;
      end else begin
         if (len < OLD_SPACE_MIN || len > OLD_SPACE_MAX) old_bad = 1'b1;
         if (len < NEW_SPACE_MIN || len > NEW_SPACE_MAX) new_bad = 1'b1;
         if (sp_idx < OldBits && len > OLD_ONE_ABOVE) old_acc[sp_idx] = 1'b1;
         if (sp_idx < NewBits && len > NEW_ONE_ABOVE) new_acc[sp_idx] = 1'b1;
         if (sp_idx != INDEX_MAX) sp_idx = sp_idx + 1'b1;
      end
      if (eob) begin
         if (ev_count == OLD_EVENTS || ev_count == NEW_EVENTS) begin
            is_new = (ev_count == NEW_EVENTS);
            elapsed = stamp - last_stamp;
            last_stamp = stamp;
            if (!(is_new ? new_bad : old_bad)) begin
               if (is_new) begin
                  code = new_acc;
                  res.ftype = FRAME_NEW;
                  res.addr = code[4:0];
                  res.cmd = code[12:5];
                  if (code[14]) begin
                     res.cmd = ~res.cmd;
                     code = code ^ CHECK_FLIP;
                  end
               end else begin
                  code = {{(NewBits-OldBits){1'b0}}, old_acc};
                  res.ftype = FRAME_OLD;
                  res.addr = '0;
                  res.cmd = {2'b00, old_acc};
               end
               if (elapsed > ELAPSED_CLAMP) elapsed = ELAPSED_CLAMP;
               res.rep = have_last && code == last_code &&
                         elapsed < {{(TimeW-WindowW){1'b0}}, repeat_window};
               last_code = code;
               have_last = 1'b1;
               frame_q.push_back(res);
               frames_predicted++;
            end
         end
         ev_count = '0;
         sp_idx = '0;
         old_acc = '0;
         new_acc = '0;
         old_bad = 1'b0;
         new_bad = 1'b0;
      end
   endfunction

   function automatic logic [LenW-1:0] mark_len();
      return LenW'($urandom_range(0, NEW_MARK_MAX));
   endfunction

   function automatic logic [LenW-1:0] space_len(input bit use_new, input bit one);
      if (use_new)
         return one ? LenW'($urandom_range(NEW_SPACE_MAX, NEW_ONE_ABOVE + 1))
                    : LenW'($urandom_range(NEW_ONE_ABOVE, NEW_SPACE_MIN));
      return one ? LenW'($urandom_range(OLD_SPACE_MAX, OLD_ONE_ABOVE + 1))
                 : LenW'($urandom_range(OLD_ONE_ABOVE, OLD_SPACE_MIN));
   endfunction

   task automatic send_pulse(input logic sp, input logic [LenW-1:0] len, input logic eob,
                             input logic [TimeW-1:0] stamp);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_is_space <= sp;
      req_length_us <= len;
      req_end_of_burst <= eob;
      req_time_us <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_pulse(sp, len, eob, stamp);
      pulses_sent++;
   endtask

   task automatic build_frame(input bit use_new, input logic [NewBits-1:0] bits);
      int nbits;
      nbits = use_new ? NewBits : OldBits;
      burst_q.delete();
      for (int i = 0; i < nbits; i++) begin
         burst_q.push_back(ir_pulse_type'({1'b0, mark_len()}));
         burst_q.push_back(ir_pulse_type'({1'b1, space_len(use_new, bits[i])}));
      end
      burst_q.push_back(ir_pulse_type'({1'b0, mark_len()}));
   endtask

   task automatic patch_pulse(input int k, input logic sp, input logic [LenW-1:0] len);
      burst_q[k] = ir_pulse_type'({sp, len});
   endtask

   task automatic play_after(input logic [TimeW-1:0] delta);
      int last;
      last = burst_q.size() - 1;
      stamp_now = stamp_now + delta;
      for (int i = 0; i <= last; i++)
         send_pulse(burst_q[i].is_space, burst_q[i].len, i == last,
                    (i == last) ? stamp_now : TimeW'($urandom()));
      burst_q.delete();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [WindowW-1:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      repeat_window = value;
   endtask

   task automatic test_format_decode();
      build_frame(1'b0, 15'h003F);
      play_after(32'd100000);
      build_frame(1'b0, 15'h0000);
      play_after(32'd100000);
      build_frame(1'b1, 15'h0AB5);
      play_after(32'd100000);
      build_frame(1'b1, 15'h5234);
      play_after(32'd100000);
      build_frame(1'b1, 15'h5234);
      play_after(32'd1000);
      wait_idle();
      build_frame(1'b0, 15'h0015);
      play_after(32'd100000);
      build_frame(1'b1, 15'h0015);
      play_after(32'd2000);
      build_frame(1'b1, 15'h7FFF);
      play_after(32'd2000);
   endtask

   task automatic test_length_limits();
      logic [LenW-1:0] old_edges [7] = '{16'd749, 16'd750, 16'd2500, 16'd2501,
                                        16'd7000, 16'd7001, 16'd0};
      logic [LenW-1:0] new_edges [7] = '{16'd339, 16'd340, 16'd1180, 16'd1181,
                                        16'd3360, 16'd3361, 16'hFFFF};
      logic [LenW-1:0] mark_edges [5] = '{16'd1000, 16'd1001, 16'd640, 16'd641, 16'hFFFF};
      foreach (old_edges[i]) begin
         build_frame(1'b0, NewBits'($urandom()));
         patch_pulse(1, 1'b1, old_edges[i]);
         play_after(32'($urandom_range(20000, 200000)));
      end
      foreach (new_edges[i]) begin
         build_frame(1'b1, NewBits'($urandom()));
         patch_pulse(1, 1'b1, new_edges[i]);
         play_after(32'($urandom_range(20000, 200000)));
      end
      foreach (mark_edges[i]) begin
         build_frame(i < 2 ? 1'b0 : 1'b1, NewBits'($urandom()));
         patch_pulse(0, 1'b0, mark_edges[i]);
         play_after(32'($urandom_range(20000, 200000)));
      end
   endtask

   task automatic test_burst_shapes();
      steady = 1'b1;
      build_frame(1'b0, 15'h0011);
      void'(burst_q.pop_back());
      play_after(32'd50000);
      burst_q.push_back(ir_pulse_type'({1'b0, mark_len()}));
      play_after(32'd50000);
      for (int i = 0; i < 70; i++)
         burst_q.push_back(ir_pulse_type'({i[0], space_len(1'b1, $urandom_range(0, 1))}));
      play_after(32'd50000);
      steady = 1'b0;
      for (int i = 0; i < 13; i++) burst_q.push_back(ir_pulse_type'({1'b1, 16'd3000}));
      play_after(32'd50000);
      for (int i = 0; i < 13; i++) burst_q.push_back(ir_pulse_type'({1'b1, 16'd3000}));
      patch_pulse(10, 1'b1, 16'd8000);
      play_after(32'd50000);
      for (int i = 0; i < 11; i++) begin
         burst_q.push_back(ir_pulse_type'({1'b0, mark_len()}));
         burst_q.push_back(ir_pulse_type'({1'b1, space_len(1'b1, $urandom_range(0, 1))}));
      end
      for (int i = 0; i < 9; i++)
         burst_q.push_back(ir_pulse_type'({1'b1, space_len(1'b1, $urandom_range(0, 1))}));
      play_after(32'd50000);
      build_frame(1'b0, 15'h002A);
      play_after(32'd200000);
      build_frame(1'b0, 15'h002A);
      patch_pulse(0, 1'b0, 16'd1001);
      play_after(32'd200000);
      build_frame(1'b0, 15'h002A);
      play_after(32'd10000);
   endtask

   task automatic test_elapsed_time();
      write_window(20'd1000000);
      build_frame(1'b1, 15'h1357);
      play_after(32'd100000);
      build_frame(1'b1, 15'h1357);
      play_after(32'd999999);
      build_frame(1'b1, 15'h1357);
      play_after(32'd1000000);
      build_frame(1'b1, 15'h1357);
      play_after(32'hF000_0000);
      stamp_now = 32'hFFFF_FF00;
      build_frame(1'b0, 15'h0009);
      play_after(32'd0);
      build_frame(1'b0, 15'h0009);
      play_after(32'h0000_0200);
      write_window(20'd0);
      build_frame(1'b0, 15'h0009);
      play_after(32'd0);
      write_window(WINDOW_RESET);
      build_frame(1'b0, 15'h0009);
      play_after(32'd79999);
      build_frame(1'b0, 15'h0009);
      play_after(32'd80000);
   endtask

   task automatic test_random_traffic();
      int               first_pulse;
      int               first_frame;
      int               pick;
      int               len_n;
      bit               use_new;
      logic [NewBits-1:0] bits;
      logic [NewBits-1:0] prev_bits;
      logic [TimeW-1:0] delta;
      first_pulse = pulses_sent;
      first_frame = frames_predicted;
      prev_bits = '0;
      while (pulses_sent - first_pulse < RANDOM_PULSES ||
             frames_predicted - first_frame < RANDOM_FRAMES) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) wait_idle();
         if (pick < 4) begin
            case ($urandom_range(0, 3))
               0: write_window(20'd0);
               1: write_window(20'd1000000);
               2: write_window(WINDOW_RESET);
               default: write_window(WindowW'($urandom_range(0, 1000000)));
            endcase
         end
         if ($urandom_range(0, 9) == 0) steady = !steady;
         use_new = $urandom_range(0, 1);
         bits = ($urandom_range(0, 2) == 0) ? prev_bits : NewBits'($urandom());
         prev_bits = bits;
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            build_frame(use_new, bits);
            if (pick >= 70)
               patch_pulse($urandom_range(0, burst_q.size() - 1), $urandom_range(0, 1),
                           LenW'($urandom_range(0, 65535)));
         end else begin
            case ($urandom_range(0, 2))
               0: len_n = OLD_EVENTS;
               1: len_n = NEW_EVENTS;
               default: len_n = $urandom_range(1, 45);
            endcase
            for (int i = 0; i < len_n; i++)
               burst_q.push_back(ir_pulse_type'({1'($urandom_range(0, 1)),
                                                 LenW'($urandom_range(0, 65535))}));
         end
         delta = ($urandom_range(0, 9) == 0) ? TimeW'($urandom())
                                             : TimeW'($urandom_range(0, 120000));
         play_after(delta);
      end
      steady = 1'b0;
   endtask

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_q.size() == 0) begin
               $display("%0t: unexpected result beat, expected none actual type %0d cmd %0h",
                        $time, rsp_frame_type, rsp_command);
               errors++;
            end else begin
               front_res = frame_q.pop_front();
               check_field("frame_type", front_res.ftype, rsp_frame_type);
               check_field("address", front_res.addr, rsp_address);
               check_field("command", front_res.cmd, rsp_command);
               check_field("repeat_res", front_res.rep, rsp_repeat_res);
            end
            hold_left = steady ? 0 : $urandom_range(0, 4);
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_format_decode();
      test_length_limits();
      test_burst_shapes();
      test_elapsed_time();
      test_random_traffic();
      req_valid <= 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
